// ===== src/positional_list_engine_core_macros.svh =====
// Assertion macros for the checker file of the list engine.
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define PLE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list engine check failed");

// Check a consequent in the cycle after its antecedent.
`define PLE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list engine check failed");

// Check a delayed consequent against its antecedent.
`define PLE_ASSERT_DLY3(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##3 (cons)) \
		else $error("list engine check failed");

`endif

// ===== src/ple_pkg.sv =====
package ple_pkg;

	// Request operation codes
	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_SWAP   = 2'd2,
		FN_GET    = 2'd3
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic apply;
	} ctrl_t;

	localparam int unsigned POS_A_BITS = 7;
	localparam int unsigned POS_B_BITS = 6;
	localparam int unsigned HANDLE_BITS = 32;
	localparam int unsigned COUNT_BITS = 7;

endpackage

// ===== src/ple_ctrl.sv =====
module ple_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output ple_pkg::ctrl_t ctrl
);
	import ple_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	// Take a request whenever the check cycle is not in progress
	assign accept = start && !busy_q;
	assign busy = busy_q;

	assign ctrl.load  = accept;
	assign ctrl.exec  = (state_q == S_EXEC);
	assign ctrl.apply = (state_q == S_APPLY);

	// Advance the sequence: check and read, then apply and report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_APPLY;
					busy_q  <= 1'b0;
				end
				S_APPLY: begin
					if (accept) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== src/ple_dp.sv =====
module ple_dp #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned ENTRY_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ple_pkg::ctrl_t                      ctrl,
	input  logic [1:0]                          func,
	input  logic [ple_pkg::POS_A_BITS-1:0]      pos_a,
	input  logic [ple_pkg::POS_B_BITS-1:0]      pos_b,
	input  logic [ple_pkg::HANDLE_BITS-1:0]     entry_in,
	output logic [ple_pkg::HANDLE_BITS-1:0]     entry_out,
	output logic [1:0]                          status,
	output logic [ple_pkg::COUNT_BITS-1:0]      count,
	output logic                                done
);
	import ple_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > POS_A_BITS) ? CW : POS_A_BITS;
	localparam int unsigned XW = (ENTRY_BITS > HANDLE_BITS) ? ENTRY_BITS : HANDLE_BITS;

	// Request registers
	func_t                   func_q;
	logic [POS_A_BITS-1:0]   pa_q;
	logic [POS_B_BITS-1:0]   pb_q;
	logic [ENTRY_BITS-1:0]   val_q;
	logic [XW-1:0]           vin_x;

	// List state
	logic [ENTRY_BITS-1:0]   cells_q [DEPTH];
	logic [CW-1:0]           count_q;

	// Check-stage results
	func_t                   func_s1;
	status_t                 st_s1;
	logic [AW-1:0]           ia_s1;
	logic [AW-1:0]           ib_s1;
	logic [ENTRY_BITS-1:0]   rda_s1;
	logic [ENTRY_BITS-1:0]   rdb_s1;
	logic [ENTRY_BITS-1:0]   val_s1;

	// Result registers
	logic [HANDLE_BITS-1:0]  entry_out_q;
	status_t                 status_q;
	logic                    done_q;

	logic [PW-1:0]           pa_w;
	logic [PW-1:0]           pb_w;
	logic [PW-1:0]           cnt_w;
	logic                    full;
	logic                    empty;
	status_t                 st_w;
	logic [AW-1:0]           ia_w;
	logic [AW-1:0]           ib_w;
	logic                    ok;
	logic [CW-1:0]           count_nxt;
	logic [XW-1:0]           rda_x;

	assign vin_x = XW'(entry_in);

	// Capture the request on transfer
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			func_q <= func_t'(func);
			pa_q   <= pos_a;
			pb_q   <= pos_b;
			val_q  <= vin_x[ENTRY_BITS-1:0];
		end
	end

	// Check positions against the count
	assign pa_w  = PW'(pa_q);
	assign pb_w  = PW'(pb_q);
	assign cnt_w = PW'(count_q);
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		st_w = ST_OK;
		unique case (func_q)
			FN_INSERT: begin
				if (full)
					st_w = ST_FULL;
				else if (!empty && (pa_w > cnt_w))
					st_w = ST_BOUNDS;
			end
			FN_SWAP: begin
				if (empty)
					st_w = ST_EMPTY;
				else if ((pa_w >= cnt_w) || (pb_w >= cnt_w))
					st_w = ST_BOUNDS;
			end
			default: begin
				if (empty)
					st_w = ST_EMPTY;
				else if (pa_w >= cnt_w)
					st_w = ST_BOUNDS;
			end
		endcase
	end

	// Insert into an empty list goes in front
	assign ia_w = (func_q == FN_INSERT && empty) ? '0 : pa_w[AW-1:0];
	assign ib_w = pb_w[AW-1:0];

	// Hold check results and the read entries for the apply cycle
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			func_s1 <= func_q;
			st_s1   <= st_w;
			ia_s1   <= ia_w;
			ib_s1   <= ib_w;
			rda_s1  <= cells_q[ia_w];
			rdb_s1  <= cells_q[ib_w];
			val_s1  <= val_q;
		end
	end

	assign ok = (st_s1 == ST_OK);

	// Shift, write or swap every cell in parallel
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ENTRY_BITS-1:0] prev;
		logic [ENTRY_BITS-1:0] nxt;

		if (i == 0) begin : g_first
			assign prev = val_s1;
		end else begin : g_inner
			assign prev = cells_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign nxt = cells_q[i];
		end else begin : g_body
			assign nxt = cells_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (ctrl.apply && ok) begin
				unique case (func_s1)
					FN_INSERT: begin
						if (AW'(i) == ia_s1)
							cells_q[i] <= val_s1;
						else if ((AW'(i) > ia_s1) && (CW'(i) <= count_q))
							cells_q[i] <= prev;
					end
					FN_REMOVE: begin
						if ((AW'(i) >= ia_s1) && (CW'(i + 1) < count_q))
							cells_q[i] <= nxt;
					end
					FN_SWAP: begin
						if (AW'(i) == ia_s1)
							cells_q[i] <= rdb_s1;
						else if (AW'(i) == ib_s1)
							cells_q[i] <= rda_s1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Update the count
	always_comb begin
		count_nxt = count_q;
		if (ok && func_s1 == FN_INSERT)
			count_nxt = count_q + CW'(1);
		else if (ok && func_s1 == FN_REMOVE)
			count_nxt = count_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctrl.apply;
			if (ctrl.apply)
				count_q <= count_nxt;
		end
	end

	// Register the result payload
	assign rda_x = XW'(rda_s1);

	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			status_q <= st_s1;
			if (ok && (func_s1 == FN_REMOVE || func_s1 == FN_GET))
				entry_out_q <= rda_x[HANDLE_BITS-1:0];
			else
				entry_out_q <= '0;
		end
	end

	// Drive the result ports from the result registers
	assign entry_out = entry_out_q;
	assign status    = status_q;
	assign count     = COUNT_BITS'(count_q);
	assign done      = done_q;

endmodule

// ===== src/positional_list_engine_core.sv =====
// Positional list engine: an ordered list of up to DEPTH entry handles.
// Request channel: drive func, pos_a, pos_b and entry_in with start high;
// the request transfers at a rising edge where start is high and busy is
// low. busy is high in the check state that follows each transfer.
// Result channel: done is high for exactly one cycle with entry_out,
// status and count; the receiver cannot hold results off.
// Sequence: the check state checks positions and reads the addressed cells,
// then the apply state shifts or writes the row of cells in parallel and
// registers the result; done is registered from the apply state. A new
// request can transfer in the apply state, but not in the check state.
// Insert and remove move the cells from the position onward by one position
// in parallel, so the cost does not depend on the position or the count.
// Reset: arst_n clears the count and the controller; cell contents are not
// cleared, since only entries at positions below the count are ever used.
module positional_list_engine_core #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned ENTRY_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       func,
	input  logic [ple_pkg::POS_A_BITS-1:0]   pos_a,
	input  logic [ple_pkg::POS_B_BITS-1:0]   pos_b,
	input  logic [ple_pkg::HANDLE_BITS-1:0]  entry_in,
	output logic                             done,
	output logic [ple_pkg::HANDLE_BITS-1:0]  entry_out,
	output logic [1:0]                       status,
	output logic [ple_pkg::COUNT_BITS-1:0]   count
);
	import ple_pkg::*;

	ctrl_t ctrl;

	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	ple_dp #(
		.DEPTH      (DEPTH),
		.ENTRY_BITS (ENTRY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.func      (func),
		.pos_a     (pos_a),
		.pos_b     (pos_b),
		.entry_in  (entry_in),
		.entry_out (entry_out),
		.status    (status),
		.count     (count),
		.done      (done)
	);

endmodule

// ===== src/ple_assert.sv =====
`include "positional_list_engine_core_macros.svh"

module ple_assert (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [ple_pkg::HANDLE_BITS-1:0]  entry_out,
	input logic [1:0]                       status,
	input logic [ple_pkg::COUNT_BITS-1:0]   count
);
	import ple_pkg::*;

	// A transfer makes the block busy in the next cycle
	`PLE_ASSERT_NXT(a_busy_after_xfer, start && !busy, busy)

	// Busy lasts one cycle
	`PLE_ASSERT_NXT(a_busy_one_cycle, busy, !busy)

	// Every transfer yields its result on done
	`PLE_ASSERT_DLY3(a_result_latency, start && !busy, done)

	// A failed request returns no entry
	`PLE_ASSERT_IMP(a_err_no_entry, done && (status != ST_OK), entry_out == '0)

	// An empty-list error reports a zero count
	`PLE_ASSERT_IMP(a_empty_count, done && (status == ST_EMPTY), count == '0)

endmodule

bind positional_list_engine_core ple_assert u_ple_assert (.*);

// ===== test/tb.sv =====
module tb;
	import ple_pkg::*;

	localparam int unsigned LIST_DEPTH = 64;

	// Expected reply for one request
	typedef struct {
		logic [HANDLE_BITS-1:0] entry;
		status_t                st;
		logic [COUNT_BITS-1:0]  cnt;
	} list_reply_t;

	typedef enum int {
		MIX_GROW,
		MIX_BALANCED,
		MIX_SHRINK
	} traffic_mix_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              func;
	logic [POS_A_BITS-1:0]   pos_a;
	logic [POS_B_BITS-1:0]   pos_b;
	logic [HANDLE_BITS-1:0]  entry_in;
	logic                    done;
	logic [HANDLE_BITS-1:0]  entry_out;
	logic [1:0]              status;
	logic [COUNT_BITS-1:0]   count;

	// Shadow copy of the list contents and length
	logic [HANDLE_BITS-1:0]  shadow_entries [LIST_DEPTH];
	int                      shadow_count;
	list_reply_t             pending_replies [$];
	int                      mismatch_count;
	int                      sender_idle_pct;

	positional_list_engine_core #(
		.DEPTH      (LIST_DEPTH),
		.ENTRY_BITS (HANDLE_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.pos_a     (pos_a),
		.pos_b     (pos_b),
		.entry_in  (entry_in),
		.done      (done),
		.entry_out (entry_out),
		.status    (status),
		.count     (count)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one request to the shadow list and queue the reply it gives
	task automatic list_update(input func_t f, input int pa, input int pb,
			input logic [HANDLE_BITS-1:0] val);
		list_reply_t            r;
		logic [HANDLE_BITS-1:0] t;
		r.entry = '0;
		r.st    = ST_OK;
		case (f)
			FN_INSERT: begin
				if (shadow_count >= LIST_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					if (shadow_count == 0)
						pa = 0;
					if (pa > shadow_count) begin
						r.st = ST_BOUNDS;
					end else begin
						for (int i = shadow_count; i > pa; i--)
							shadow_entries[i] = shadow_entries[i-1];
						shadow_entries[pa] = val;
						shadow_count++;
					end
				end
			end
			FN_REMOVE: begin
				if (shadow_count == 0) begin
					r.st = ST_EMPTY;
				end else if (pa >= shadow_count) begin
					r.st = ST_BOUNDS;
				end else begin
					r.entry = shadow_entries[pa];
					for (int i = pa; i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
				end
			end
			FN_SWAP: begin
				if (shadow_count == 0) begin
					r.st = ST_EMPTY;
				end else if (pa >= shadow_count || pb >= shadow_count) begin
					r.st = ST_BOUNDS;
				end else begin
					t = shadow_entries[pa];
					shadow_entries[pa] = shadow_entries[pb];
					shadow_entries[pb] = t;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					r.st = ST_EMPTY;
				end else if (pa >= shadow_count) begin
					r.st = ST_BOUNDS;
				end else begin
					r.entry = shadow_entries[pa];
				end
			end
		endcase
		r.cnt = shadow_count[COUNT_BITS-1:0];
		pending_replies.push_back(r);
	endtask

	// Drive one request after a random idle gap and hold it until it transfers
	task automatic issue_request(input func_t f, input logic [POS_A_BITS-1:0] pa,
			input logic [POS_B_BITS-1:0] pb, input logic [HANDLE_BITS-1:0] val);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct)
			gap++;
		repeat (gap) @(negedge clk) start <= 1'b0;
		@(negedge clk);
		start    <= 1'b1;
		func     <= f;
		pos_a    <= pa;
		pos_b    <= pb;
		entry_in <= val;
		do @(posedge clk); while (busy);
		list_update(f, pa, pb, val);
	endtask

	// Drop start and hold until every queued reply has come back
	task automatic wait_replies();
		@(negedge clk) start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Pick a position: mostly in range, sometimes anywhere in the field
	function automatic logic [POS_A_BITS-1:0] pick_pos_a(input int hi);
		if (hi >= 0 && $urandom_range(99) < 85)
			return POS_A_BITS'($urandom_range(hi));
		return POS_A_BITS'($urandom_range((1 << POS_A_BITS) - 1));
	endfunction

	function automatic logic [POS_B_BITS-1:0] pick_pos_b(input int hi);
		if (hi >= 0 && $urandom_range(99) < 85)
			return POS_B_BITS'($urandom_range(hi));
		return POS_B_BITS'($urandom_range((1 << POS_B_BITS) - 1));
	endfunction

	// Compare each reply with the oldest expectation
	always @(posedge clk) begin
		list_reply_t exp_r;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$error("reply with no request outstanding");
				mismatch_count++;
			end else begin
				exp_r = pending_replies.pop_front();
				if (entry_out !== exp_r.entry) begin
					$error("entry_out: expected %h, actual %h", exp_r.entry, entry_out);
					mismatch_count++;
				end
				if (status !== exp_r.st) begin
					$error("status: expected %0d, actual %0d", exp_r.st, status);
					mismatch_count++;
				end
				if (count !== exp_r.cnt) begin
					$error("count: expected %0d, actual %0d", exp_r.cnt, count);
					mismatch_count++;
				end
			end
		end
	end

	// Requests on an empty list, and insert with the position ignored
	task automatic test_empty_list();
		issue_request(FN_GET, 7'd0, 6'd0, 32'h0);
		issue_request(FN_REMOVE, 7'd0, 6'd0, 32'h0);
		issue_request(FN_SWAP, 7'd0, 6'd0, 32'h0);
		issue_request(FN_INSERT, 7'd127, 6'd63, 32'hFFFF_FFFF);
		issue_request(FN_GET, 7'd0, 6'd0, 32'h0);
		issue_request(FN_REMOVE, 7'd0, 6'd0, 32'h0);
		wait_replies();
	endtask

	// Bounds on every operation, swaps with itself and across the list
	task automatic test_positions();
		issue_request(FN_INSERT, 7'd5, 6'd0, 32'h0000_0000);
		issue_request(FN_INSERT, 7'd1, 6'd0, 32'hA5A5_A5A5);
		issue_request(FN_INSERT, 7'd0, 6'd0, 32'h5A5A_5A5A);
		issue_request(FN_INSERT, 7'd4, 6'd0, 32'hDEAD_BEEF);
		issue_request(FN_INSERT, 7'd3, 6'd0, 32'h0000_0001);
		issue_request(FN_GET, 7'd4, 6'd0, 32'h0);
		issue_request(FN_GET, 7'd127, 6'd0, 32'h0);
		issue_request(FN_REMOVE, 7'd4, 6'd0, 32'h0);
		issue_request(FN_SWAP, 7'd0, 6'd63, 32'h0);
		issue_request(FN_SWAP, 7'd63, 6'd0, 32'h0);
		issue_request(FN_SWAP, 7'd1, 6'd1, 32'h0);
		issue_request(FN_SWAP, 7'd0, 6'd3, 32'h0);
		issue_request(FN_GET, 7'd0, 6'd0, 32'h0);
		issue_request(FN_GET, 7'd3, 6'd0, 32'h0);
		issue_request(FN_REMOVE, 7'd1, 6'd0, 32'h0);
		issue_request(FN_REMOVE, 7'd2, 6'd0, 32'h0);
		wait_replies();
	endtask

	// Fill the list, then insert into it full and work at the last position
	task automatic test_full_list();
		while (shadow_count < LIST_DEPTH)
			issue_request(FN_INSERT, pick_pos_a(shadow_count), pick_pos_b(-1), $urandom);
		issue_request(FN_INSERT, 7'd0, 6'd0, $urandom);
		issue_request(FN_INSERT, 7'd127, 6'd0, $urandom);
		issue_request(FN_GET, 7'd64, 6'd0, 32'h0);
		issue_request(FN_GET, 7'd63, 6'd0, 32'h0);
		issue_request(FN_SWAP, 7'd63, 6'd0, 32'h0);
		issue_request(FN_REMOVE, 7'd63, 6'd0, 32'h0);
		issue_request(FN_INSERT, 7'd63, 6'd0, $urandom);
		issue_request(FN_REMOVE, 7'd0, 6'd0, 32'h0);
		wait_replies();
	endtask

	// Random traffic in segments that grow, balance and shrink the list
	task automatic test_random_traffic(input int idle_pct, input int n_items);
		traffic_mix_t mix;
		int           r;
		int           ins_lim;
		int           rem_lim;
		int           swp_lim;
		func_t        f;
		sender_idle_pct = idle_pct;
		for (int n = 0; n < n_items; n++) begin
			case ((n / 100) % 4)
				0:       mix = MIX_GROW;
				2:       mix = MIX_SHRINK;
				default: mix = MIX_BALANCED;
			endcase
			case (mix)
				MIX_GROW: begin
					ins_lim = 80; rem_lim = 88; swp_lim = 94;
				end
				MIX_SHRINK: begin
					ins_lim = 15; rem_lim = 75; swp_lim = 87;
				end
				default: begin
					ins_lim = 35; rem_lim = 65; swp_lim = 82;
				end
			endcase
			r = $urandom_range(99);
			if (r < ins_lim)
				f = FN_INSERT;
			else if (r < rem_lim)
				f = FN_REMOVE;
			else if (r < swp_lim)
				f = FN_SWAP;
			else
				f = FN_GET;
			if (f == FN_INSERT)
				issue_request(f, pick_pos_a(shadow_count), pick_pos_b(-1), $urandom);
			else
				issue_request(f, pick_pos_a(shadow_count - 1),
					pick_pos_b(shadow_count - 1), $urandom);
		end
		wait_replies();
	endtask

	// Reset, run each test in turn, report
	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		func            = FN_INSERT;
		pos_a           = '0;
		pos_b           = '0;
		entry_in        = '0;
		shadow_count    = 0;
		mismatch_count  = 0;
		sender_idle_pct = 20;
		foreach (shadow_entries[i])
			shadow_entries[i] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_empty_list();
		test_positions();
		test_full_list();
		test_random_traffic(20, 400);
		test_random_traffic(61, 400);
		test_random_traffic(0, 400);

		if (mismatch_count == 0)
			$display("PASS positional_list_engine_core");
		else
			$display("FAIL positional_list_engine_core");
		$finish;
	end

	// Stop a hung run
	initial begin
		#3000000;
		$display("FAIL positional_list_engine_core");
		$finish;
	end

endmodule
